// File: rtl/i2cmr_pkg.sv
// Package for the I2C master with bus recovery.
// Holds command codes, the sequencer phase type and the item/result structs.
// No dependencies.
package i2cmr_pkg;

  localparam logic [2:0] MODE_TICK    = 3'd0;
  localparam logic [2:0] MODE_INIT    = 3'd1;
  localparam logic [2:0] MODE_START   = 3'd2;
  localparam logic [2:0] MODE_RESTART = 3'd3;
  localparam logic [2:0] MODE_STOP    = 3'd4;
  localparam logic [2:0] MODE_WRITE   = 3'd5;
  localparam logic [2:0] MODE_READ    = 3'd6;
  localparam logic [2:0] MODE_RSVD    = 3'd7;  // unused code, handled as a tick

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NACK  = 2'd1;
  localparam logic [1:0] ST_STUCK = 2'd2;

  localparam logic [3:0] RECOVERY_PULSES_RST = 4'd10;
  localparam logic [3:0] BITS_PER_BYTE       = 4'd8;

  typedef enum logic [10:0] {
    PH_IDLE    = 11'b000_0000_0001,
    PH_CHECK   = 11'b000_0000_0010,
    PH_PULSE   = 11'b000_0000_0100,
    PH_RSTOP   = 11'b000_0000_1000,
    PH_START   = 11'b000_0001_0000,
    PH_RESTART = 11'b000_0010_0000,
    PH_STOP    = 11'b000_0100_0000,
    PH_WBIT    = 11'b000_1000_0000,
    PH_WACK    = 11'b001_0000_0000,
    PH_RBIT    = 11'b010_0000_0000,
    PH_RACK    = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] data_byte;
    logic       send_nack;
    logic       sda_in;
    logic       scl_in;
  } item_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] read_data;
  } res_t;

endpackage

// File: rtl/i2cmr_seq.sv
// Bus sequencer: command latch and one delay unit per tick transfer.
// Result for the current item is combinational; state updates on step.
// Depends on i2cmr_pkg.
module i2cmr_seq
  import i2cmr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [3:0] recovery_pulses,
  input  item_t      item,
  output res_t       res
);

  phase_t     phase, phase_next;
  logic [2:0] active_cmd, active_cmd_next;
  logic [3:0] bit_index, bit_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [3:0] pulse_index, pulse_index_next;
  logic       nack_choice, nack_choice_next;
  logic [1:0] last_status, last_status_next;
  logic       scl_level, scl_level_next;
  logic       sda_level, sda_level_next;
  logic [1:0] unit_step, unit_step_next;
  logic [7:0] last_read, last_read_next;
  logic       done;
  logic       both_high;
  logic       is_cmd;
  logic [3:0] pulse_inc;
  logic [3:0] bit_inc;
  phase_t     after_ok;
  logic       after_ok_done;

  assign both_high = item.sda_in & item.scl_in;
  assign is_cmd    = (item.mode != MODE_TICK) && (item.mode != MODE_RSVD);
  assign pulse_inc = pulse_index + 4'd1;
  assign bit_inc   = bit_index + 4'd1;
  // init finishes after a clean check, start goes on to the start condition
  assign after_ok      = (active_cmd == MODE_INIT) ? PH_IDLE : PH_START;
  assign after_ok_done = (active_cmd == MODE_INIT);

  always_comb begin
    phase_next       = phase;
    active_cmd_next  = active_cmd;
    bit_index_next   = bit_index;
    shift_byte_next  = shift_byte;
    pulse_index_next = pulse_index;
    nack_choice_next = nack_choice;
    last_status_next = last_status;
    scl_level_next   = scl_level;
    sda_level_next   = sda_level;
    unit_step_next   = unit_step;
    last_read_next   = last_read;
    done             = 1'b0;

    if (is_cmd) begin
      if (phase == PH_IDLE) begin
        active_cmd_next  = item.mode;
        unit_step_next   = 2'd0;
        bit_index_next   = 4'd0;
        pulse_index_next = 4'd0;
        unique case (item.mode)
          MODE_INIT, MODE_START: phase_next = PH_CHECK;
          MODE_RESTART:          phase_next = PH_RESTART;
          MODE_STOP:             phase_next = PH_STOP;
          MODE_WRITE: begin
            phase_next       = PH_WBIT;
            shift_byte_next  = item.data_byte;
            nack_choice_next = 1'b0;
          end
          default: begin
            phase_next       = PH_RBIT;
            shift_byte_next  = 8'd0;
            nack_choice_next = item.send_nack;
          end
        endcase
      end
    end else begin
      unique case (phase)
        PH_IDLE: ;
        PH_CHECK: begin
          scl_level_next = 1'b1;
          sda_level_next = 1'b1;
          if (both_high) begin
            phase_next     = after_ok;
            unit_step_next = 2'd0;
            done           = after_ok_done;
            if (after_ok_done) last_status_next = ST_OK;
          end else begin
            pulse_index_next = 4'd0;
            unit_step_next   = 2'd0;
            phase_next       = (recovery_pulses == 4'd0) ? PH_RSTOP : PH_PULSE;
          end
        end
        PH_PULSE: begin
          sda_level_next = 1'b1;
          scl_level_next = (unit_step < 2'd2);
          unit_step_next = unit_step + 2'd1;
          if (unit_step == 2'd3) begin
            pulse_index_next = pulse_inc;
            if (pulse_inc >= recovery_pulses) phase_next = PH_RSTOP;
          end
        end
        PH_RSTOP: begin
          if (unit_step == 2'd0) begin
            scl_level_next = 1'b0;
            sda_level_next = 1'b0;
            unit_step_next = 2'd1;
          end else if (unit_step == 2'd1) begin
            scl_level_next = 1'b1;
            unit_step_next = 2'd2;
          end else begin
            sda_level_next = 1'b1;
            unit_step_next = 2'd0;
            if (both_high) begin
              phase_next = after_ok;
              done       = after_ok_done;
              if (after_ok_done) last_status_next = ST_OK;
            end else begin
              phase_next       = PH_IDLE;
              done             = 1'b1;
              last_status_next = ST_STUCK;
            end
          end
        end
        PH_START, PH_RESTART: begin
          if (unit_step == 2'd0) begin
            scl_level_next = 1'b1;
            sda_level_next = 1'b1;
            unit_step_next = 2'd1;
          end else if (unit_step == 2'd1) begin
            sda_level_next = 1'b0;
            unit_step_next = 2'd2;
          end else begin
            scl_level_next   = 1'b0;
            phase_next       = PH_IDLE;
            unit_step_next   = 2'd0;
            done             = 1'b1;
            last_status_next = ST_OK;
          end
        end
        PH_STOP: begin
          if (unit_step == 2'd0) begin
            sda_level_next = 1'b0;
            unit_step_next = 2'd1;
          end else if (unit_step == 2'd1) begin
            scl_level_next = 1'b1;
            unit_step_next = 2'd2;
          end else begin
            sda_level_next   = 1'b1;
            phase_next       = PH_IDLE;
            unit_step_next   = 2'd0;
            done             = 1'b1;
            last_status_next = ST_OK;
          end
        end
        PH_WBIT: begin
          unit_step_next = unit_step + 2'd1;
          if (unit_step == 2'd0) begin
            sda_level_next = shift_byte[7];
          end else if (unit_step == 2'd1) begin
            scl_level_next = 1'b1;
          end else if (unit_step == 2'd3) begin
            scl_level_next  = 1'b0;
            shift_byte_next = {shift_byte[6:0], 1'b0};
            bit_index_next  = bit_inc;
            if (bit_inc >= BITS_PER_BYTE) phase_next = PH_WACK;
          end
        end
        PH_WACK: begin
          unit_step_next = unit_step + 2'd1;
          if (unit_step == 2'd0) begin
            sda_level_next = 1'b1;
          end else if (unit_step == 2'd1) begin
            scl_level_next   = 1'b1;
            nack_choice_next = item.sda_in;
          end else if (unit_step == 2'd3) begin
            scl_level_next   = 1'b0;
            phase_next       = PH_IDLE;
            unit_step_next   = 2'd0;
            done             = 1'b1;
            last_status_next = nack_choice ? ST_NACK : ST_OK;
          end
        end
        PH_RBIT: begin
          sda_level_next = 1'b1;
          unit_step_next = unit_step + 2'd1;
          if (unit_step == 2'd1) begin
            scl_level_next  = 1'b1;
            shift_byte_next = {shift_byte[6:0], item.sda_in};
          end else if (unit_step == 2'd3) begin
            scl_level_next = 1'b0;
            bit_index_next = bit_inc;
            if (bit_inc >= BITS_PER_BYTE) phase_next = PH_RACK;
          end
        end
        PH_RACK: begin
          unit_step_next = unit_step + 2'd1;
          if (unit_step == 2'd0) begin
            sda_level_next = nack_choice;
          end else if (unit_step == 2'd1) begin
            scl_level_next = 1'b1;
          end else if (unit_step == 2'd3) begin
            scl_level_next   = 1'b0;
            last_read_next   = shift_byte;
            phase_next       = PH_IDLE;
            unit_step_next   = 2'd0;
            done             = 1'b1;
            last_status_next = ST_OK;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.scl_release = scl_level_next;
    res.sda_release = sda_level_next;
    res.busy_res    = (phase_next != PH_IDLE);
    res.done_res    = done;
    res.status      = last_status_next;
    res.read_data   = last_read_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      active_cmd  <= MODE_TICK;
      bit_index   <= 4'd0;
      shift_byte  <= 8'd0;
      pulse_index <= 4'd0;
      nack_choice <= 1'b0;
      last_status <= ST_OK;
      scl_level   <= 1'b1;
      sda_level   <= 1'b1;
      unit_step   <= 2'd0;
      last_read   <= 8'd0;
    end else if (step) begin
      phase       <= phase_next;
      active_cmd  <= active_cmd_next;
      bit_index   <= bit_index_next;
      shift_byte  <= shift_byte_next;
      pulse_index <= pulse_index_next;
      nack_choice <= nack_choice_next;
      last_status <= last_status_next;
      scl_level   <= scl_level_next;
      sda_level   <= sda_level_next;
      unit_step   <= unit_step_next;
      last_read   <= last_read_next;
    end
  end

endmodule

// File: rtl/i2c_master_with_bus_recovery.sv
// I2C master with stuck-bus recovery: one transfer in gives one result transfer out.
// Each item is either a command (latched when idle) or a tick that advances the
// bus sequence by one delay unit; the result holds the line drives and status.
// Throughput is one item per clock while the skid register is empty: next state and
// result are computed combinationally from the state registers; the result is
// registered in the output register, or in the skid register while the output
// register is held. A two-entry output stage (output register plus skid register)
// lets input continue while a result is held; input stalls only when both entries
// are full. recovery_pulses resets to 10 and must be written only while no
// command is in progress. Depends on i2cmr_pkg and i2cmr_seq.
module i2c_master_with_bus_recovery
  import i2cmr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] mode,
  input  logic [7:0] data_byte,
  input  logic       send_nack,
  input  logic       sda_in,
  input  logic       scl_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       scl_release,
  output logic       sda_release,
  output logic       busy_res,
  output logic       done_res,
  output logic [1:0] status,
  output logic [7:0] read_data
);

  logic [3:0] recovery_pulses;
  item_t      item;
  res_t       res_new;
  res_t       out_res;
  res_t       skid_res;
  logic       skid_valid;
  logic       push;
  logic       pop;

  assign in_ready = !skid_valid;
  assign push     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  assign item.mode      = mode;
  assign item.data_byte = data_byte;
  assign item.send_nack = send_nack;
  assign item.sda_in    = sda_in;
  assign item.scl_in    = scl_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      recovery_pulses <= RECOVERY_PULSES_RST;
    end else if (cfg_we) begin
      recovery_pulses <= cfg_data;
    end
  end

  i2cmr_seq u_seq (
    .clk             (clk),
    .rst             (rst),
    .step            (push),
    .recovery_pulses (recovery_pulses),
    .item            (item),
    .res             (res_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_res <= skid_res;
        if (push) skid_res <= res_new;
      end else if (push) begin
        out_res <= res_new;
      end
    end else if (push) begin
      skid_res <= res_new;
    end
  end

  assign scl_release = out_res.scl_release;
  assign sda_release = out_res.sda_release;
  assign busy_res    = out_res.busy_res;
  assign done_res    = out_res.done_res;
  assign status      = out_res.status;
  assign read_data   = out_res.read_data;

`ifndef SYNTHESIS
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without an output entry");

  a_done_not_busy : assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> !busy_res)
    else $error("finished sequence still reported busy");

  a_status_code : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= ST_STUCK))
    else $error("undefined status code on output");

  a_full_stalls : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && skid_valid) |=> (skid_valid && out_valid))
    else $error("held results dropped while output stalled");
`endif

endmodule

// File: dv/i2c_master_with_bus_recovery_tb.sv
// Testbench for i2c_master_with_bus_recovery: drives command and tick transfers,
// predicts line drives and status per transfer, and checks every result transfer.
// Depends on i2cmr_pkg and the RTL of the block.
module i2c_master_with_bus_recovery_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cmr_pkg::*;

  localparam int WDOG_LIMIT = 2000;
  localparam int ITEM_TARGET = 1250;
  localparam int ITEM_W = $bits(item_t);

  typedef enum logic [1:0] {FLT_NONE, FLT_CLEARS, FLT_STUCK} fault_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [3:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic [2:0] mode;
  logic [7:0] data_byte;
  logic       send_nack;
  logic       sda_in;
  logic       scl_in;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       scl_release;
  logic       sda_release;
  logic       busy_res;
  logic       done_res;
  logic [1:0] status;
  logic [7:0] read_data;

  // predicted bus master state
  logic [3:0] rec_pulses;
  phase_t     ph;
  logic [2:0] act_cmd;
  logic [3:0] bit_idx;
  logic [7:0] shreg;
  logic [3:0] pulse_idx;
  logic       nack_bit;
  logic [1:0] last_st;
  logic       scl_lvl;
  logic       sda_lvl;
  logic [1:0] ustep;
  logic [7:0] rd_byte;
  logic       done_bit;

  res_t bus_state_q[$];

  int fail_cnt;
  int item_cnt;
  int noise_pct;
  int burst_left;
  int idle_cnt = 0;
  int rx_mode = 0;
  logic [15:0] rx_cnt = '0;

  i2c_master_with_bus_recovery DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .data_byte   (data_byte),
    .send_nack   (send_nack),
    .sda_in      (sda_in),
    .scl_in      (scl_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .scl_release (scl_release),
    .sda_release (sda_release),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .status      (status),
    .read_data   (read_data)
  );

  always #2 clk = ~clk;

  function automatic void end_cmd(logic [1:0] st);
    last_st = st;
    ph = PH_IDLE;
    ustep = 2'd0;
    done_bit = 1'b1;
  endfunction

  function automatic void line_check_ok();
    if (act_cmd == MODE_INIT) begin
      end_cmd(ST_OK);
    end else begin
      ph = PH_START;
      ustep = 2'd0;
    end
  endfunction

  function automatic void bus_tick(logic sda, logic scl);
    logic both;
    both = sda & scl;
    case (ph)
      PH_CHECK: begin
        scl_lvl = 1'b1;
        sda_lvl = 1'b1;
        if (both) begin
          line_check_ok();
        end else begin
          pulse_idx = 4'd0;
          ustep = 2'd0;
          ph = (rec_pulses == 4'd0) ? PH_RSTOP : PH_PULSE;
        end
      end
      PH_PULSE: begin
        sda_lvl = 1'b1;
        scl_lvl = (ustep < 2'd2);
        ustep = ustep + 2'd1;
        if (ustep == 2'd0) begin
          pulse_idx = pulse_idx + 4'd1;
          if (pulse_idx >= rec_pulses) ph = PH_RSTOP;
        end
      end
      PH_RSTOP: begin
        if (ustep == 2'd0) begin
          scl_lvl = 1'b0;
          sda_lvl = 1'b0;
          ustep = 2'd1;
        end else if (ustep == 2'd1) begin
          scl_lvl = 1'b1;
          ustep = 2'd2;
        end else begin
          sda_lvl = 1'b1;
          if (both) line_check_ok();
          else end_cmd(ST_STUCK);
        end
      end
      PH_START, PH_RESTART: begin
        if (ustep == 2'd0) begin
          scl_lvl = 1'b1;
          sda_lvl = 1'b1;
          ustep = 2'd1;
        end else if (ustep == 2'd1) begin
          sda_lvl = 1'b0;
          ustep = 2'd2;
        end else begin
          scl_lvl = 1'b0;
          end_cmd(ST_OK);
        end
      end
      PH_STOP: begin
        if (ustep == 2'd0) begin
          sda_lvl = 1'b0;
          ustep = 2'd1;
        end else if (ustep == 2'd1) begin
          scl_lvl = 1'b1;
          ustep = 2'd2;
        end else begin
          sda_lvl = 1'b1;
          end_cmd(ST_OK);
        end
      end
      PH_WBIT: begin
        case (ustep)
          2'd0: sda_lvl = shreg[7];
          2'd1: scl_lvl = 1'b1;
          2'd3: begin
            scl_lvl = 1'b0;
            shreg = shreg << 1;
            bit_idx = bit_idx + 4'd1;
          end
          default: ;
        endcase
        ustep = ustep + 2'd1;
        if (ustep == 2'd0 && bit_idx >= BITS_PER_BYTE) ph = PH_WACK;
      end
      PH_WACK: begin
        if (ustep == 2'd3) begin
          scl_lvl = 1'b0;
          end_cmd(nack_bit ? ST_NACK : ST_OK);
        end else begin
          if (ustep == 2'd0) begin
            sda_lvl = 1'b1;
          end else if (ustep == 2'd1) begin
            scl_lvl = 1'b1;
            nack_bit = sda;
          end
          ustep = ustep + 2'd1;
        end
      end
      PH_RBIT: begin
        sda_lvl = 1'b1;
        if (ustep == 2'd1) begin
          scl_lvl = 1'b1;
          shreg = {shreg[6:0], sda};
        end else if (ustep == 2'd3) begin
          scl_lvl = 1'b0;
          bit_idx = bit_idx + 4'd1;
        end
        ustep = ustep + 2'd1;
        if (ustep == 2'd0 && bit_idx >= BITS_PER_BYTE) ph = PH_RACK;
      end
      PH_RACK: begin
        if (ustep == 2'd3) begin
          scl_lvl = 1'b0;
          rd_byte = shreg;
          end_cmd(ST_OK);
        end else begin
          if (ustep == 2'd0) sda_lvl = nack_bit;
          else if (ustep == 2'd1) scl_lvl = 1'b1;
          ustep = ustep + 2'd1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void i2c_step(item_t it);
    res_t r;
    done_bit = 1'b0;
    if (it.mode >= MODE_INIT && it.mode <= MODE_READ) begin
      if (ph == PH_IDLE) begin
        act_cmd = it.mode;
        ustep = 2'd0;
        bit_idx = 4'd0;
        pulse_idx = 4'd0;
        case (it.mode)
          MODE_INIT, MODE_START: ph = PH_CHECK;
          MODE_RESTART: ph = PH_RESTART;
          MODE_STOP: ph = PH_STOP;
          MODE_WRITE: begin
            ph = PH_WBIT;
            shreg = it.data_byte;
            nack_bit = 1'b0;
          end
          default: begin
            ph = PH_RBIT;
            shreg = 8'd0;
            nack_bit = it.send_nack;
          end
        endcase
      end
    end else begin
      bus_tick(it.sda_in, it.scl_in);
    end
    r.scl_release = scl_lvl;
    r.sda_release = sda_lvl;
    r.busy_res    = (ph != PH_IDLE);
    r.done_res    = done_bit;
    r.status      = last_st;
    r.read_data   = rd_byte;
    bus_state_q.push_back(r);
  endfunction

  // sender: bursts of back-to-back transfers separated by random gaps
  task automatic push_item(item_t it);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    burst_left = burst_left - 1;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    {mode, data_byte, send_nack, sda_in, scl_in} <= it;
    do @(posedge clk); while (!in_ready);
    i2c_step(it);
  endtask

  task automatic wait_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (bus_state_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_pulses(logic [3:0] n);
    wait_results();
    repeat (3) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= n;
    @(negedge clk);
    cfg_we <= 1'b0;
    rec_pulses = n;
  endtask

  // one command followed by ticks, mixed with stray commands at noise_pct, until it completes; line samples follow flt
  task automatic run_command(logic [2:0] cmd, logic [7:0] dat, logic nack, fault_t flt,
                             logic ack_lvl, logic [7:0] bus_byte);
    item_t it;
    int sel;
    it.mode = cmd;
    it.data_byte = dat;
    it.send_nack = nack;
    it.sda_in = 1'($urandom_range(0, 1));
    it.scl_in = 1'($urandom_range(0, 1));
    push_item(it);
    item_cnt++;
    while (ph != PH_IDLE) begin
      it.data_byte = 8'($urandom);
      it.send_nack = 1'($urandom_range(0, 1));
      it.sda_in = 1'($urandom_range(0, 1));
      it.scl_in = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < noise_pct) begin
        it.mode = 3'($urandom_range(MODE_INIT, MODE_READ));
        push_item(it);
      end else begin
        it.mode = ($urandom_range(0, 19) == 0) ? MODE_RSVD : MODE_TICK;
        case (ph)
          PH_CHECK, PH_RSTOP: begin
            if (flt == FLT_STUCK || (flt == FLT_CLEARS && ph == PH_CHECK)) begin
              sel = $urandom_range(0, 2);
              it.sda_in = (sel == 2);
              it.scl_in = (sel == 1);
            end else begin
              it.sda_in = 1'b1;
              it.scl_in = 1'b1;
            end
          end
          PH_WACK: it.sda_in = ack_lvl;
          PH_RBIT: it.sda_in = bus_byte[7 - bit_idx[2:0]];
          default: ;
        endcase
        push_item(it);
        item_cnt++;
      end
    end
  endtask

  task automatic test_idle_items();
    item_t it;
    it = '0;
    it.mode = MODE_TICK;
    push_item(it);
    it.mode = MODE_RSVD;
    it.data_byte = 8'hFF;
    it.send_nack = 1'b1;
    push_item(it);
  endtask

  task automatic test_init_paths();
    run_command(MODE_INIT, 8'h00, 1'b0, FLT_NONE, 1'b0, 8'h00);
    run_command(MODE_INIT, 8'h00, 1'b0, FLT_CLEARS, 1'b0, 8'h00);
    run_command(MODE_INIT, 8'h00, 1'b0, FLT_STUCK, 1'b0, 8'h00);
  endtask

  task automatic test_recovery_counts();
    set_pulses(4'd0);
    run_command(MODE_INIT, 8'h00, 1'b0, FLT_STUCK, 1'b0, 8'h00);
    run_command(MODE_START, 8'h00, 1'b0, FLT_CLEARS, 1'b0, 8'h00);
    set_pulses(4'd15);
    run_command(MODE_START, 8'h00, 1'b0, FLT_CLEARS, 1'b0, 8'h00);
    set_pulses(4'd1);
    run_command(MODE_START, 8'h00, 1'b0, FLT_STUCK, 1'b0, 8'h00);
    set_pulses(RECOVERY_PULSES_RST);
  endtask

  task automatic test_byte_transfers();
    run_command(MODE_START, 8'h00, 1'b0, FLT_NONE, 1'b0, 8'h00);
    run_command(MODE_WRITE, 8'hFF, 1'b0, FLT_NONE, 1'b0, 8'h00);
    run_command(MODE_WRITE, 8'h00, 1'b0, FLT_NONE, 1'b1, 8'h00);
    run_command(MODE_READ, 8'h00, 1'b0, FLT_NONE, 1'b0, 8'hA5);
    run_command(MODE_READ, 8'hFF, 1'b1, FLT_NONE, 1'b0, 8'h5A);
    run_command(MODE_RESTART, 8'h00, 1'b0, FLT_NONE, 1'b0, 8'h00);
    run_command(MODE_WRITE, 8'h80, 1'b0, FLT_NONE, 1'b0, 8'h00);
    run_command(MODE_READ, 8'h00, 1'b1, FLT_NONE, 1'b0, 8'h01);
    run_command(MODE_STOP, 8'h00, 1'b0, FLT_NONE, 1'b0, 8'h00);
  endtask

  task automatic test_busy_commands();
    noise_pct = 50;
    run_command(MODE_WRITE, 8'h3C, 1'b0, FLT_NONE, 1'b0, 8'h00);
    run_command(MODE_READ, 8'h00, 1'b0, FLT_NONE, 1'b0, 8'hC3);
    run_command(MODE_START, 8'h00, 1'b0, FLT_CLEARS, 1'b0, 8'h00);
    run_command(MODE_STOP, 8'h00, 1'b0, FLT_NONE, 1'b0, 8'h00);
    noise_pct = 0;
  endtask

  task automatic test_random();
    int cmd_cnt;
    int pick;
    logic [2:0] cmd;
    logic [7:0] dat;
    fault_t flt;
    item_t it;
    cmd_cnt = 0;
    noise_pct = 4;
    while (item_cnt < ITEM_TARGET) begin
      if (cmd_cnt % 12 == 11) begin
        if ($urandom_range(0, 3) == 0) set_pulses(4'($urandom_range(0, 15)));
        else set_pulses(4'($urandom_range(1, 4)));
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) cmd = MODE_INIT;
      else if (pick < 22) cmd = MODE_START;
      else if (pick < 30) cmd = MODE_RESTART;
      else if (pick < 40) cmd = MODE_STOP;
      else if (pick < 70) cmd = MODE_WRITE;
      else cmd = MODE_READ;
      pick = $urandom_range(0, 99);
      if (pick < 70) flt = FLT_NONE;
      else if (pick < 88) flt = FLT_CLEARS;
      else flt = FLT_STUCK;
      pick = $urandom_range(0, 7);
      if (pick == 0) dat = 8'h00;
      else if (pick == 1) dat = 8'hFF;
      else dat = 8'($urandom);
      run_command(cmd, dat, 1'($urandom_range(0, 1)), flt, ($urandom_range(0, 3) == 0),
                  8'($urandom));
      if ($urandom_range(0, 9) == 0) begin
        it = ITEM_W'($urandom);
        it.mode = ($urandom_range(0, 1) == 0) ? MODE_TICK : MODE_RSVD;
        push_item(it);
      end
      cmd_cnt++;
    end
    noise_pct = 0;
  endtask

  // receiver stall pattern, switched whenever the low byte of rx_cnt wraps to zero
  always @(negedge clk) begin
    rx_cnt <= rx_cnt + 16'd1;
    if (rx_cnt[7:0] == 8'd0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (rx_cnt[1:0] != 2'd0);
      default: out_ready <= (rx_cnt[3:0] >= 4'd12);
    endcase
  end

  always @(posedge clk) begin : check_results
    res_t exp_r;
    res_t got;
    if (!rst && out_valid && out_ready) begin
      got = {scl_release, sda_release, busy_res, done_res, status, read_data};
      if (bus_state_q.size() == 0) begin
        $error("result transfer with no expected result");
        fail_cnt++;
      end else begin
        exp_r = bus_state_q.pop_front();
        if (got.scl_release !== exp_r.scl_release) begin
          $error("scl_release: expected %0d, got %0d", exp_r.scl_release, got.scl_release);
          fail_cnt++;
        end
        if (got.sda_release !== exp_r.sda_release) begin
          $error("sda_release: expected %0d, got %0d", exp_r.sda_release, got.sda_release);
          fail_cnt++;
        end
        if (got.busy_res !== exp_r.busy_res) begin
          $error("busy_res: expected %0d, got %0d", exp_r.busy_res, got.busy_res);
          fail_cnt++;
        end
        if (got.done_res !== exp_r.done_res) begin
          $error("done_res: expected %0d, got %0d", exp_r.done_res, got.done_res);
          fail_cnt++;
        end
        if (got.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, got.status);
          fail_cnt++;
        end
        if (got.read_data !== exp_r.read_data) begin
          $error("read_data: expected 0x%02h, got 0x%02h", exp_r.read_data, got.read_data);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = 4'd0;
    in_valid = 1'b0;
    mode = MODE_TICK;
    data_byte = 8'd0;
    send_nack = 1'b0;
    sda_in = 1'b1;
    scl_in = 1'b1;
    rec_pulses = RECOVERY_PULSES_RST;
    ph = PH_IDLE;
    act_cmd = 3'd0;
    bit_idx = 4'd0;
    shreg = 8'd0;
    pulse_idx = 4'd0;
    nack_bit = 1'b0;
    last_st = ST_OK;
    scl_lvl = 1'b1;
    sda_lvl = 1'b1;
    ustep = 2'd0;
    rd_byte = 8'd0;
    done_bit = 1'b0;
    fail_cnt = 0;
    item_cnt = 0;
    noise_pct = 0;
    burst_left = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_idle_items();
    test_init_paths();
    test_recovery_counts();
    test_byte_transfers();
    test_busy_commands();
    test_random();

    wait_results();
    repeat (8) @(posedge clk);
    if (bus_state_q.size() != 0) begin
      $error("%0d expected results never arrived", bus_state_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
